@@ hdl/pler_pkg.sv @@
// types and constants for the per-layer energy renormaliser
`timescale 1ns / 1ps
package pler_pkg;

    localparam int unsigned EnergyW = 32;
    localparam int unsigned LayerW  = 5;
    localparam int unsigned IndexW  = 12;
    localparam int unsigned OpW     = 2;
    localparam int unsigned ProdW   = 64;

    typedef enum logic [OpW-1:0] {
        OP_SET_EXPECTED = 2'd0,
        OP_LOAD_CELL    = 2'd1,
        OP_READ_CELL    = 2'd2,
        OP_CLEAR        = 2'd3
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_SAT  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

endpackage

@@ hdl/per_layer_energy_renormalizer.sv @@
// per-layer energy renormaliser: cell store, layer sums and iterative divider
//
// channel | dir | tdata                                           | tuser
// s_      | in  | layer[4:0] energy[36:5] cell_index[48:37]       | op[1:0]
// m_      | out | cell_layer[4:0] scaled_energy[36:5]             | status[0] overflow[1]
//
// ops 0, 1 and 3 complete on acceptance; a readout with a non-zero layer sum passes through
// memory read, multiply, the one-bit-per-cycle restoring divider (64 steps), saturation and
// output load; a zero sum skips divider and saturation, and an unloaded index goes straight to output load.
// one item is in work at a time.
// reset zeroes the layer tables, cell count and overflow flag; no clearing pass.
// a stalled result waits in ST_FIN; no new item is taken until the output register is free.
`timescale 1ns / 1ps
module per_layer_energy_renormalizer
    import pler_pkg::*;
#(
    parameter int unsigned MAX_CELLS  = 4096,
    parameter int unsigned NUM_LAYERS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // layer, energy, cell_index
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cell_layer, scaled_energy
    output logic [1:0]  m_tuser    // status, overflow
);

    localparam int unsigned AW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned CNTW = $clog2(MAX_CELLS + 1);
    localparam int unsigned SW   = EnergyW + AW;
    localparam int unsigned LIW  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int unsigned MW   = LayerW + EnergyW;
    localparam int unsigned DCW  = $clog2(ProdW);

    // input fields
    logic [LayerW-1:0]         in_layer;
    logic signed [EnergyW-1:0] in_energy;
    logic [IndexW-1:0]         in_index;
    op_t                       in_op;
    logic [31:0]               in_index_ext;
    logic [31:0]               in_layer_ext;
    logic                      in_xfer;

    assign in_layer     = s_tdata[4:0];
    assign in_energy    = s_tdata[36:5];
    assign in_index     = s_tdata[48:37];
    assign in_op        = op_t'(s_tuser);
    assign in_index_ext = {{(32-IndexW){1'b0}}, in_index};
    assign in_layer_ext = {{(32-LayerW){1'b0}}, in_layer};
    assign in_xfer      = s_tvalid && s_tready;

    state_t state_reg, state_next;
    logic [CNTW-1:0] cnt_reg;
    logic            ovf_reg;

    logic layer_ok;
    logic index_ok;
    assign layer_ok = in_layer_ext < 32'(NUM_LAYERS);
    assign index_ok = (in_index_ext < 32'(cnt_reg)) && (in_index_ext < 32'(MAX_CELLS));

    logic signed [SW-1:0]      layer_sum_reg [NUM_LAYERS];
    logic signed [EnergyW-1:0] layer_exp_reg [NUM_LAYERS];

    // cell store
    logic [MW-1:0] cell_mem [MAX_CELLS];
    logic [MW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer && in_op == OP_LOAD_CELL && layer_ok && 32'(cnt_reg) < 32'(MAX_CELLS)) begin
            cell_mem[cnt_reg[AW-1:0]] <= {in_energy, in_layer};
        end
        if (in_xfer) begin
            rd_data_reg <= cell_mem[in_index_ext[AW-1:0]];
        end
    end

    // layer tables and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            for (int i = 0; i < NUM_LAYERS; i++) begin
                layer_sum_reg[i] <= '0;
                layer_exp_reg[i] <= '0;
            end
        end else if (in_xfer) begin
            unique case (in_op)
                OP_SET_EXPECTED: begin
                    if (layer_ok) begin
                        layer_exp_reg[in_layer_ext[LIW-1:0]] <= in_energy;
                    end
                end
                OP_LOAD_CELL: begin
                    if (layer_ok) begin
                        if (32'(cnt_reg) >= 32'(MAX_CELLS)) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            layer_sum_reg[in_layer_ext[LIW-1:0]] <=
                                layer_sum_reg[in_layer_ext[LIW-1:0]]
                                + {{(SW-EnergyW){in_energy[EnergyW-1]}}, in_energy};
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    cnt_reg <= '0;
                    for (int i = 0; i < NUM_LAYERS; i++) begin
                        layer_sum_reg[i] <= '0;
                        layer_exp_reg[i] <= '0;
                    end
                end
                OP_READ_CELL: begin
                end
                default: begin
                end
            endcase
        end
    end

    // readout datapath
    logic [LayerW-1:0]         rd_layer;
    logic signed [EnergyW-1:0] rd_energy;
    logic [31:0]               rd_layer_ext;
    logic signed [SW-1:0]      rd_sum;
    logic signed [EnergyW-1:0] rd_exp;
    logic signed [ProdW-1:0]   prod_full;

    assign rd_layer     = rd_data_reg[LayerW-1:0];
    assign rd_energy    = rd_data_reg[MW-1:LayerW];
    assign rd_layer_ext = {{(32-LayerW){1'b0}}, rd_layer};
    assign rd_sum       = layer_sum_reg[rd_layer_ext[LIW-1:0]];
    assign rd_exp       = layer_exp_reg[rd_layer_ext[LIW-1:0]];
    assign prod_full    = rd_energy * rd_exp;

    logic signed [ProdW-1:0] prod_reg;
    logic signed [SW-1:0]    sum_reg;
    logic [ProdW-1:0]        dvd_reg;
    logic [SW-1:0]           dsr_reg;
    logic [SW-1:0]           rem_reg;
    logic [DCW-1:0]          dcnt_reg;
    logic                    neg_reg;
    logic [LayerW-1:0]       res_layer_reg;
    logic [EnergyW-1:0]      res_energy_reg;
    logic                    res_status_reg;

    logic [SW:0] rem_ext;
    logic        q_bit;
    assign rem_ext = {rem_reg, dvd_reg[ProdW-1]};
    assign q_bit   = rem_ext >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        priority case (1'b1)
            state_reg[0]: begin
                if (in_xfer && in_op == OP_READ_CELL) begin
                    res_layer_reg  <= '0;
                    res_energy_reg <= '0;
                    res_status_reg <= !index_ok;
                end
            end
            state_reg[1]: begin
                prod_reg      <= prod_full;
                sum_reg       <= rd_sum;
                res_layer_reg <= rd_layer;
                res_energy_reg <= rd_energy;
            end
            state_reg[2]: begin
                dvd_reg  <= prod_reg[ProdW-1] ? ProdW'(-prod_reg) : prod_reg;
                dsr_reg  <= sum_reg[SW-1] ? SW'(-sum_reg) : sum_reg;
                rem_reg  <= '0;
                dcnt_reg <= '0;
                neg_reg  <= prod_reg[ProdW-1] ^ sum_reg[SW-1];
            end
            state_reg[3]: begin
                rem_reg  <= q_bit ? SW'(rem_ext - {1'b0, dsr_reg}) : rem_ext[SW-1:0];
                dvd_reg  <= {dvd_reg[ProdW-2:0], q_bit};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            state_reg[4]: begin
                if (neg_reg) begin
                    res_energy_reg <= (dvd_reg > ProdW'(64'h8000_0000)) ? 32'h8000_0000
                                      : 32'(-dvd_reg[31:0]);
                end else begin
                    res_energy_reg <= (dvd_reg > ProdW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                      : dvd_reg[31:0];
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer
    logic m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;
    logic        out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && in_op == OP_READ_CELL) begin
                    state_next = index_ok ? ST_RD : ST_FIN;
                end
            end
            ST_RD:  state_next = ST_MUL;
            ST_MUL: state_next = (sum_reg == '0) ? ST_FIN : ST_DIV;
            ST_DIV: state_next = (dcnt_reg == DCW'(ProdW - 1)) ? ST_SAT : ST_DIV;
            ST_SAT: state_next = ST_FIN;
            ST_FIN: state_next = out_free ? ST_IDLE : ST_FIN;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            m_tdata_reg <= {3'b000, res_energy_reg, res_layer_reg};
            m_tuser_reg <= {ovf_reg, res_status_reg};
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= 32'(MAX_CELLS))
        else $error("cell count beyond capacity");

    a_missing_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && in_op == OP_READ_CELL && !index_ok) |=> (res_status_reg && state_reg == ST_FIN))
        else $error("unloaded index not flagged");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && $past(state_reg) == ST_MUL) |-> dcnt_reg == '0)
        else $error("divider started mid count");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !out_free) |=> state_reg == ST_FIN)
        else $error("result left while output busy");
`endif

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the per-layer energy renormaliser
`timescale 1ns / 1ps
module testbench;
    import pler_pkg::*;

    localparam int MaxCells  = 4096;
    localparam int NumLayers = 24;
    localparam longint CycleLimit = 64'd2_000_000;

    typedef struct packed {
        op_t         op;
        logic [4:0]  layer;
        logic [31:0] energy;
        logic [11:0] cell_index;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  cell_layer;
        logic [31:0] scaled_energy;
        logic        status;
        logic        overflow;
    } readout_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    per_layer_energy_renormalizer u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // shadow state of the block
    logic [4:0]           shadow_layer [MaxCells];
    logic signed [31:0]   shadow_energy [MaxCells];
    logic signed [63:0]   sum_by_layer [NumLayers];
    logic signed [31:0]   expected_by_layer [NumLayers];
    int                   stored_cells;
    logic                 dropped_flag;

    cmd_t     pending_cmds[$];
    readout_t expected_readouts[$];
    int       mismatches = 0;
    longint   cycles = 0;
    bit       stimulus_done;
    bit       tail_mode;
    int       s_gap;
    int       m_gap;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic signed [31:0] saturate(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    task automatic renormalise(input cmd_t c);
        readout_t r;
        logic signed [127:0] prod;
        logic signed [127:0] sum;
        int idx;
        int lay;
        idx = c.cell_index;
        lay = c.layer;
        case (c.op)
            OP_SET_EXPECTED: begin
                if (lay < NumLayers) expected_by_layer[lay] = c.energy;
            end
            OP_LOAD_CELL: begin
                if (lay < NumLayers) begin
                    if (stored_cells >= MaxCells) begin
                        dropped_flag = 1'b1;
                    end else begin
                        shadow_layer[stored_cells]  = c.layer;
                        shadow_energy[stored_cells] = c.energy;
                        sum_by_layer[lay] += 64'(signed'(c.energy));
                        stored_cells++;
                    end
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < NumLayers; i++) begin
                    sum_by_layer[i] = '0;
                    expected_by_layer[i] = '0;
                end
                stored_cells = 0;
            end
            default: begin
                r.overflow = dropped_flag;
                if (idx >= stored_cells) begin
                    r.cell_layer = '0;
                    r.scaled_energy = '0;
                    r.status = 1'b1;
                end else begin
                    r.cell_layer = shadow_layer[idx];
                    r.status = 1'b0;
                    sum = 128'(sum_by_layer[shadow_layer[idx]]);
                    if (sum == 0) begin
                        r.scaled_energy = shadow_energy[idx];
                    end else begin
                        prod = 128'(shadow_energy[idx])
                            * 128'(expected_by_layer[shadow_layer[idx]]);
                        r.scaled_energy = saturate(prod / sum);
                    end
                end
                expected_readouts.push_back(r);
            end
        endcase
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            s_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                cmd_t c;
                c = pending_cmds.pop_front();
                renormalise(c);
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, c.cell_index, c.energy, c.layer};
                s_tuser  <= c.op;
                if (!tail_mode && $urandom_range(0, 9) == 0) s_gap <= $urandom_range(1, 16);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and result-side stall
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_gap <= 0;
        end else begin
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!tail_mode && $urandom_range(0, 15) == 0) begin
                m_gap <= $urandom_range(1, 16) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            if (m_tvalid && m_tready) begin
                readout_t got;
                readout_t want;
                got = {m_tdata[4:0], m_tdata[36:5], m_tuser[0], m_tuser[1]};
                if (expected_readouts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer: %p", got);
                end else begin
                    want = expected_readouts.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

    function automatic cmd_t random_cmd(input int fill_bias);
        cmd_t c;
        int pick;
        c.layer = $urandom_range(0, 99) < 95 ? 5'($urandom_range(0, NumLayers - 1))
                                              : 5'($urandom_range(NumLayers, 31));
        c.energy = $urandom_range(0, 3) == 0 ? $urandom()
                 : 32'($signed($urandom_range(0, 4000)) - 2000);
        c.cell_index = $urandom_range(0, 3) == 0 ? 12'($urandom())
                     : 12'($urandom_range(0, fill_bias));
        pick = $urandom_range(0, 99);
        c.op = pick < 15 ? OP_SET_EXPECTED : pick < 55 ? OP_LOAD_CELL
             : pick < 98 ? OP_READ_CELL : OP_CLEAR;
        return c;
    endfunction

    function automatic cmd_t mk(input op_t op, input int lay, input logic [31:0] e,
                                input int idx);
        cmd_t c;
        c.op = op;
        c.layer = 5'(lay);
        c.energy = e;
        c.cell_index = 12'(idx);
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || expected_readouts.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        stimulus_done = 0;
        tail_mode = 0;
        aresetn = 1'b0;
        for (int i = 0; i < NumLayers; i++) begin
            sum_by_layer[i] = '0;
            expected_by_layer[i] = '0;
        end
        stored_cells = 0;
        dropped_flag = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty read, extremes, saturation, bad layer, clear
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 0));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 4095));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 0, 32'h7fffffff, 0));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 0, 32'h80000000, 0));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 0));
        pending_cmds.push_back(mk(OP_SET_EXPECTED, 23, 32'h7fffffff, 0));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 23, 32'h80000000, 0));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 23, 1, 0));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 2));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 3));
        pending_cmds.push_back(mk(OP_SET_EXPECTED, 5, 32'h80000000, 0));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 5, -3, 0));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 5, 1, 0));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 4));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 5));
        pending_cmds.push_back(mk(OP_LOAD_CELL, 31, 77, 0));
        pending_cmds.push_back(mk(OP_SET_EXPECTED, 24, 5, 0));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 6));
        pending_cmds.push_back(mk(OP_CLEAR, 0, 0, 0));
        pending_cmds.push_back(mk(OP_READ_CELL, 0, 0, 0));
        wait_drained();

        // random well-formed phases with noise
        for (int i = 0; i < 1530; i++) begin
            if (i == 1280) tail_mode = 1;
            pending_cmds.push_back(random_cmd(stored_cells + 60));
            while (pending_cmds.size() > 8) @(posedge aclk);
        end
        wait_drained();
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done || cycles >= CycleLimit);
        if (!stimulus_done) begin
            $display("FAIL");
            $finish;
        end else begin
            if (mismatches == 0 && expected_readouts.size() == 0) begin
                $display("PASS");
            end else begin
                $display("FAIL");
            end
            $finish;
        end
    end
endmodule
